// File: design/gb5_pkg.sv
// Shared types and constants for the 5x5 Gaussian blur core.
// No dependencies; used by gb5_cell, gb5_line_store and gaussian_blur_5x5_core.
package gb5_pkg;

  localparam int unsigned PIX_W   = 8;
  localparam int unsigned WCFG_W  = 12;   // width register bits
  localparam int unsigned HCFG_W  = 16;   // height register bits
  localparam int unsigned SUM_W   = 17;   // 25-tap sum, max 273*255
  localparam int unsigned PROD_W  = 25;   // sum * 240
  localparam int unsigned IDX_W   = 8;    // config register index
  localparam int unsigned DATA_W  = 16;   // config write data

  localparam logic [IDX_W-1:0] REG_WIDTH  = IDX_W'(0);
  localparam logic [IDX_W-1:0] REG_HEIGHT = IDX_W'(1);

  localparam logic [WCFG_W-1:0] WIDTH_RST  = WCFG_W'(640);
  localparam logic [HCFG_W-1:0] HEIGHT_RST = HCFG_W'(480);
  localparam int unsigned       MIN_DIM    = 5;
  localparam int unsigned       SCALE      = 240;
  localparam int unsigned       SCALE_SH   = 16;

  // column weights by group: outer (cols 0,4), inner (cols 1,3), middle (col 2)
  // each row: weight of (top+bottom), (second+fourth), center
  localparam int unsigned WT [3][3] = '{'{1, 4, 7}, '{4, 16, 26}, '{7, 26, 41}};
  localparam int unsigned GRP_OUTER = 0;
  localparam int unsigned GRP_INNER = 1;
  localparam int unsigned GRP_MID   = 2;

  typedef logic [PIX_W-1:0]      pix_t;
  typedef logic [4:0][PIX_W-1:0] pcol_t;   // [0] oldest row .. [4] current row
  typedef logic [SUM_W-1:0]      sum_t;

  // symmetric fold of one window column
  typedef struct packed {
    logic [PIX_W:0]   outer;   // rows 0 + 4
    logic [PIX_W:0]   inner;   // rows 1 + 3
    logic [PIX_W-1:0] mid;     // row 2
  } colsum_t;

  // tag carried along the pipe with each word
  typedef struct packed {
    logic emit;
    logic last;
  } tag_t;

  function automatic sum_t grp_sum(input logic [PIX_W+1:0] a, input logic [PIX_W+1:0] b,
                                   input logic [PIX_W:0] c, input int unsigned g);
    sum_t ta, tb, tc;
    ta = SUM_W'(a) * SUM_W'(WT[g][0]);
    tb = SUM_W'(b) * SUM_W'(WT[g][1]);
    tc = SUM_W'(c) * SUM_W'(WT[g][2]);
    return ta + tb + tc;
  endfunction

endpackage

// File: design/gb5_cell.sv
// One window column of the 5x5 blur: five pixels, shifted in from the right neighbor.
// Depends on gb5_pkg.
module gb5_cell import gb5_pkg::*; (
  input  logic    clk,
  input  logic    shift,
  input  pcol_t   col_in,
  output pcol_t   col_out,
  output colsum_t sums
);

  pcol_t col;

  always_ff @(posedge clk) begin
    if (shift) begin
      col <= col_in;
    end
  end

  assign col_out    = col;
  assign sums.outer = {1'b0, col[0]} + {1'b0, col[4]};
  assign sums.inner = {1'b0, col[1]} + {1'b0, col[3]};
  assign sums.mid   = col[2];

endmodule

// File: design/gb5_line_store.sv
// Four row buffers of the blur, one bank per row slot; registered read, read-first.
// Depends on gb5_pkg.
module gb5_line_store import gb5_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [$clog2(MAX_WIDTH)-1:0] addr,
  input  logic [1:0]                   wbank,
  input  pix_t                         wdata,
  output logic [3:0][PIX_W-1:0]        rdata
);

  for (genvar b = 0; b < 4; b++) begin : g_bank
    pix_t mem [MAX_WIDTH];

    always_ff @(posedge clk) begin
      if (en) begin
        rdata[b] <= mem[addr];
        if (wbank == 2'(b)) begin
          mem[addr] <= wdata;
        end
      end
    end
  end

endmodule

// File: design/gaussian_blur_5x5_core.sv
// Top level of the streaming 5x5 Gaussian blur.
// Depends on gb5_pkg, gb5_line_store and gb5_cell.
//
// Usage:
//   pixel channel (pixel_valid/pixel_ready/pixel): 8-bit grayscale words in raster order.
//   result channel (result_valid/result_ready/blurred/frame_last): one word per
//   interior pixel (two or more pixels from every edge), in raster order;
//   frame_last marks the last interior pixel of the frame.
//   cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): index 0 image_width,
//   index 1 image_height. Any write to either restarts the frame position;
//   other indexes are ignored. Write only while the pipe is empty.
// Timing:
//   One pixel per clock unless the output stalls. A result appears on result_valid once the
//   pixel that completes its window has passed the line store read, window shift,
//   column-group sums, 25-tap total, then scale and clamp into the output register.
//   A stalled receiver holds the output register and the whole pipe; pixel_ready
//   drops only while a result is pending and result_ready is low.
// Reset: position goes to the top-left, width 640, height 480, pipe empty.
//   The line stores are not cleared; only rows of the current frame reach a result.
module gaussian_blur_5x5_core import gb5_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 2048
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_ready,
  input  pix_t              pixel,
  output logic              result_valid,
  input  logic              result_ready,
  output pix_t              blurred,
  output logic              frame_last,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [DATA_W-1:0] cfg_data
);

  localparam int unsigned COL_W = $clog2(MAX_WIDTH);
  localparam int unsigned CMP_W = (COL_W + 1 > WCFG_W) ? COL_W + 1 : WCFG_W;

  // configuration
  logic [WCFG_W-1:0] image_width;
  logic [HCFG_W-1:0] image_height;
  logic              cfg_wr;
  logic [CMP_W-1:0]  eff_w;
  logic [HCFG_W-1:0] eff_h;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && ((cfg_index == REG_WIDTH) || (cfg_index == REG_HEIGHT));

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= WIDTH_RST;
      image_height <= HEIGHT_RST;
    end else if (cfg_valid) begin
      if (cfg_index == REG_WIDTH) begin
        image_width <= cfg_data[WCFG_W-1:0];
      end
      if (cfg_index == REG_HEIGHT) begin
        image_height <= cfg_data[HCFG_W-1:0];
      end
    end
  end

  always_comb begin
    eff_w = CMP_W'(image_width);
    if (eff_w < CMP_W'(MIN_DIM)) eff_w = CMP_W'(MIN_DIM);
    if (eff_w > CMP_W'(MAX_WIDTH)) eff_w = CMP_W'(MAX_WIDTH);
    eff_h = (image_height < HCFG_W'(MIN_DIM)) ? HCFG_W'(MIN_DIM) : image_height;
  end

  // handshake: whole pipe advances unless a result is stuck at the output
  logic en, accept;
  assign en          = !result_valid || result_ready;
  assign pixel_ready = en;
  assign accept      = pixel_valid && en;

  // frame position
  logic [COL_W-1:0]  col_cnt;
  logic [HCFG_W-1:0] row_cnt;
  logic              col_end, row_end;

  assign col_end = (CMP_W'(col_cnt) == eff_w - CMP_W'(1));
  assign row_end = (row_cnt == eff_h - HCFG_W'(1));

  always_ff @(posedge clk) begin
    if (rst || cfg_wr) begin
      col_cnt <= '0;
      row_cnt <= '0;
    end else if (accept) begin
      if (col_end) begin
        col_cnt <= '0;
        row_cnt <= row_end ? '0 : row_cnt + HCFG_W'(1);
      end else begin
        col_cnt <= col_cnt + COL_W'(1);
      end
    end
  end

  // stage 1: line store read, current pixel replaces the oldest row
  logic [3:0][PIX_W-1:0] rd;
  logic                  s1_v;
  tag_t                  tag1;
  pix_t                  px1;
  logic [1:0]            rsel1;

  gb5_line_store #(.MAX_WIDTH(MAX_WIDTH)) u_lines (
    .clk   (clk),
    .en    (accept),
    .addr  (col_cnt),
    .wbank (row_cnt[1:0]),
    .wdata (pixel),
    .rdata (rd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_v <= 1'b0;
    end else if (en) begin
      s1_v <= pixel_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      px1       <= pixel;
      rsel1     <= row_cnt[1:0];
      tag1.emit <= (row_cnt >= HCFG_W'(4)) && (CMP_W'(col_cnt) >= CMP_W'(4));
      tag1.last <= row_end && col_end;
    end
  end

  // stage 2: window shift through the cell chain
  pcol_t       new_col;
  pcol_t [5:0] link;
  colsum_t     cs [5];
  logic        shift;

  always_comb begin
    for (int k = 0; k < 4; k++) begin
      new_col[k] = rd[2'(rsel1 + 2'(k))];
    end
    new_col[4] = px1;
  end

  assign shift   = en && s1_v;
  assign link[5] = new_col;

  for (genvar j = 0; j < 5; j++) begin : g_cell
    gb5_cell u_cell (
      .clk     (clk),
      .shift   (shift),
      .col_in  (link[j+1]),
      .col_out (link[j]),
      .sums    (cs[j])
    );
  end

  logic s2_v, s2_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_v <= 1'b0;
    end else if (en) begin
      s2_v <= s1_v && tag1.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_last <= tag1.last;
    end
  end

  // stage 3: column-group sums
  logic s3_v, s3_last;
  sum_t g_out, g_in, g_mid;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_v <= 1'b0;
    end else if (en) begin
      s3_v <= s2_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_last <= s2_last;
      g_out <= grp_sum({1'b0, cs[0].outer} + {1'b0, cs[4].outer},
                       {1'b0, cs[0].inner} + {1'b0, cs[4].inner},
                       {1'b0, cs[0].mid} + {1'b0, cs[4].mid}, GRP_OUTER);
      g_in  <= grp_sum({1'b0, cs[1].outer} + {1'b0, cs[3].outer},
                       {1'b0, cs[1].inner} + {1'b0, cs[3].inner},
                       {1'b0, cs[1].mid} + {1'b0, cs[3].mid}, GRP_INNER);
      g_mid <= grp_sum({1'b0, cs[2].outer}, {1'b0, cs[2].inner},
                       {1'b0, cs[2].mid}, GRP_MID);
    end
  end

  // stage 4: 25-tap total
  logic s4_v, s4_last;
  sum_t total;

  always_ff @(posedge clk) begin
    if (rst) begin
      s4_v <= 1'b0;
    end else if (en) begin
      s4_v <= s3_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_last <= s3_last;
      total   <= g_out + g_in + g_mid;
    end
  end

  // stage 5: scale, clamp, output register
  logic [PROD_W-1:0]           prod;
  logic [PROD_W-SCALE_SH-1:0]  scaled;

  assign prod   = PROD_W'(total) * PROD_W'(SCALE);
  assign scaled = prod[PROD_W-1:SCALE_SH];

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (en) begin
      result_valid <= s4_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      frame_last <= s4_last;
      blurred    <= scaled[PROD_W-SCALE_SH-1:PIX_W] != '0 ? '1 : scaled[PIX_W-1:0];
    end
  end

  // checks
  a_ready_stall: assert property (@(posedge clk) disable iff (rst)
    !pixel_ready |-> (result_valid && !result_ready))
    else $error("pixel_ready low without an output stall");

  a_cfg_restart: assert property (@(posedge clk) disable iff (rst)
    cfg_wr |=> (col_cnt == '0 && row_cnt == '0))
    else $error("config write did not restart the frame");

  a_pipe_hold: assert property (@(posedge clk) disable iff (rst)
    (s4_v && !en) |=> (s4_v && $stable(total)))
    else $error("pipe moved during an output stall");

  a_col_range: assert property (@(posedge clk) disable iff (rst)
    CMP_W'(col_cnt) < eff_w || $past(cfg_wr))
    else $error("column position beyond row width");

endmodule
